/* design/krm_pkg.sv */
// ----------------------------------------------------------------------------
// krm_pkg
// shared types and codes of the keyboard report merger
// ----------------------------------------------------------------------------
package krm_pkg;

  // one key code or modifier bitmap
  typedef logic [7:0] key_t;

  localparam int   KEY_W    = 8;
  localparam int   IN_KEYS  = 6;  // key slots carried on the ports
  localparam key_t KEY_NONE = 8'h00;

  // command codes, carried in tuser
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOCAL   = 2'd0;
  localparam cmd_t CMD_REMOTE  = 2'd1;
  localparam cmd_t CMD_RELEASE = 2'd2;

  localparam int IN_DATA_W  = 64;  // source index, modifiers, six keys
  localparam int OUT_DATA_W = 56;  // modifiers, six keys

endpackage

/* design/keyboard_report_merger_top.sv */
// ----------------------------------------------------------------------------
// keyboard_report_merger_top
// keeps the last boot-keyboard report of each local keyboard and of one
// remote keyboard and returns the merged report after every command
// ----------------------------------------------------------------------------
// usage
//   slave stream: one beat per command. tuser holds the command (store local,
//   store remote, release all), tdata the source index, modifiers and six
//   key codes. a local store with an index at or above LOCAL_SOURCES stores
//   nothing, an unused command changes nothing; both still give a report
//   master stream: one beat per command with the merged report
//   timing: the accept cycle applies the command to the stored reports, then
//   a walk over (LOCAL_SOURCES+1)*KEY_SLOTS stored keys runs, one key a cycle
//   through a shared compare-and-insert unit, then the hold state moves the
//   result to the output register once that register is free
//   tready is high only while no walk runs; a finished report waits in the
//   output register while the next command is taken. if the receiver stalls
//   with a report already waiting, the next walk result holds until it drains
//   reset: all stored reports read as zero, no beat is pending
// ----------------------------------------------------------------------------
module keyboard_report_merger_top #(
  parameter int LOCAL_SOURCES = 4,
  parameter int KEY_SLOTS     = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // source_index, in_modifiers, in_key_0 .. in_key_5
  input  logic [krm_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // cmd
  input  krm_pkg::cmd_t                      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_modifiers, out_key_0 .. out_key_5
  output logic [krm_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import krm_pkg::*;

  localparam int LW = (LOCAL_SOURCES > 1) ? $clog2(LOCAL_SOURCES) : 1;
  localparam int SW = $clog2(LOCAL_SOURCES + 1);
  localparam int KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [SW-1:0] src_q, src_d;
  logic [KW-1:0] slot_q, slot_d;

  // stored reports
  key_t local_mods_q [LOCAL_SOURCES];
  key_t local_keys_q [LOCAL_SOURCES][KEY_SLOTS];
  key_t remote_mods_q;
  key_t remote_keys_q [KEY_SLOTS];

  // merge accumulator
  key_t merge_mods_q;
  key_t merge_keys_q [KEY_SLOTS];
  key_t step_keys [KEY_SLOTS];

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;

  logic       in_beat;
  logic       out_free;
  logic       src_remote;
  logic       last_slot;
  logic       last_src;
  key_t       cur_key;
  key_t       cur_mods;
  key_t       in_mods;
  logic [7:0] in_index;
  key_t       load_keys [KEY_SLOTS];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_index        = s_axis_tdata_i[7:0];
  assign in_mods         = s_axis_tdata_i[15:8];

  // incoming keys; slots past the port width load as empty
  for (genvar j = 0; j < KEY_SLOTS; j++) begin : g_load
    if (j < IN_KEYS) begin : g_port
      assign load_keys[j] = s_axis_tdata_i[16+KEY_W*j +: KEY_W];
    end else begin : g_zero
      assign load_keys[j] = KEY_NONE;
    end
  end

  // walk position: local sources in order, remote last
  assign src_remote = (src_q == SW'(LOCAL_SOURCES));
  assign last_slot  = (slot_q == KW'(KEY_SLOTS - 1));
  assign last_src   = src_remote;
  assign cur_key    = src_remote ? remote_keys_q[slot_q]
                                 : local_keys_q[src_q[LW-1:0]][slot_q];
  assign cur_mods   = src_remote ? remote_mods_q : local_mods_q[src_q[LW-1:0]];

  krm_slot_unit #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_slot_unit (
    .keys_i (merge_keys_q),
    .key_i  (cur_key),
    .keys_o (step_keys)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_WALK;
          src_d   = '0;
          slot_d  = '0;
        end
      end
      ST_WALK: begin
        if (last_slot) begin
          slot_d = '0;
          if (last_src) begin
            state_d = ST_HOLD;
          end else begin
            src_d = src_q + SW'(1);
          end
        end else begin
          slot_d = slot_q + KW'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      src_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      slot_q  <= slot_d;
    end
  end

  // stored reports, changed only on an accepted command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_mods_q <= KEY_NONE;
      for (int s = 0; s < LOCAL_SOURCES; s++) begin
        local_mods_q[s] <= KEY_NONE;
        for (int j = 0; j < KEY_SLOTS; j++) begin
          local_keys_q[s][j] <= KEY_NONE;
        end
      end
      for (int j = 0; j < KEY_SLOTS; j++) begin
        remote_keys_q[j] <= KEY_NONE;
      end
    end else if (in_beat) begin
      case (s_axis_tuser_i)
        CMD_LOCAL: begin
          // out-of-range index stores nothing
          if (in_index < 8'(LOCAL_SOURCES)) begin
            local_mods_q[in_index[LW-1:0]] <= in_mods;
            for (int j = 0; j < KEY_SLOTS; j++) begin
              local_keys_q[in_index[LW-1:0]][j] <= load_keys[j];
            end
          end
        end
        CMD_REMOTE: begin
          remote_mods_q <= in_mods;
          for (int j = 0; j < KEY_SLOTS; j++) begin
            remote_keys_q[j] <= load_keys[j];
          end
        end
        CMD_RELEASE: begin
          remote_mods_q <= KEY_NONE;
          for (int s = 0; s < LOCAL_SOURCES; s++) begin
            local_mods_q[s] <= KEY_NONE;
            for (int j = 0; j < KEY_SLOTS; j++) begin
              local_keys_q[s][j] <= KEY_NONE;
            end
          end
          for (int j = 0; j < KEY_SLOTS; j++) begin
            remote_keys_q[j] <= KEY_NONE;
          end
        end
        default: begin
          // unused command leaves the state alone
        end
      endcase
    end
  end

  // merge accumulator: cleared on accept, one key per walk cycle
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      merge_mods_q <= KEY_NONE;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        merge_keys_q[j] <= KEY_NONE;
      end
    end else if (state_q == ST_WALK) begin
      if (slot_q == '0) begin
        merge_mods_q <= merge_mods_q | cur_mods;
      end
      merge_keys_q <= step_keys;
    end
  end

  // output beat layout; slots past KEY_SLOTS read as empty
  assign out_data_d[KEY_W-1:0] = merge_mods_q;
  for (genvar j = 0; j < IN_KEYS; j++) begin : g_out
    if (j < KEY_SLOTS) begin : g_slot
      assign out_data_d[KEY_W*(j+1) +: KEY_W] = merge_keys_q[j];
    end else begin : g_zero
      assign out_data_d[KEY_W*(j+1) +: KEY_W] = KEY_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // an accepted command always starts a walk
  a_beat_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_WALK))
    else $error("accepted beat did not start a walk");

  // walk counters stay inside the stored reports
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((src_q <= SW'(LOCAL_SOURCES)) &&
                              (slot_q <= KW'(KEY_SLOTS - 1))))
    else $error("walk counter out of range");

  // a finished report waits while the previous one is stalled
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_HOLD) && out_valid_q && !m_axis_tready_i)
      |=> ((state_q == ST_HOLD) && out_valid_q))
    else $error("report moved over a stalled output");

  // release clears the remote modifiers
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (s_axis_tuser_i == CMD_RELEASE)) |=> (remote_mods_q == KEY_NONE))
    else $error("release left remote modifiers set");

endmodule

/* design/krm_slot_unit.sv */
// ----------------------------------------------------------------------------
// krm_slot_unit
// merges one key into the merged slot set: skips empty and duplicate keys,
// otherwise fills the lowest empty slot, drops the key when all are full
// ----------------------------------------------------------------------------
module krm_slot_unit #(
  parameter int KEY_SLOTS = 6
) (
  input  krm_pkg::key_t keys_i [KEY_SLOTS],
  input  krm_pkg::key_t key_i,
  output krm_pkg::key_t keys_o [KEY_SLOTS]
);
  import krm_pkg::*;

  logic hit;
  logic placed;

  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (keys_i[j] == key_i) begin
        hit = 1'b1;
      end
    end
    placed = (key_i == KEY_NONE) || hit;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      keys_o[j] = keys_i[j];
      if (!placed && (keys_i[j] == KEY_NONE)) begin
        keys_o[j] = key_i;
        placed    = 1'b1;
      end
    end
  end

endmodule
